// File: src/pdmm_pkg.sv
// Shared widths, register indexes and reset values for the PID motor mixer.
// Used by the channel interfaces and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pdmm_pkg;

	// Field widths.
	localparam int PitchW    = 16;
	localparam int DutyW     = 16;
	localparam int GainW     = 20;
	localparam int LimitW    = 23;
	localparam int SpeedW    = 16;
	localparam int MotorLimW = 32;
	localparam int CfgAddrW  = 3;
	localparam int CfgDataW  = 32;

	// Register indexes on the configuration channel.
	localparam logic [CfgAddrW-1:0] RegSetpoint   = 3'd0;
	localparam logic [CfgAddrW-1:0] RegGainP      = 3'd1;
	localparam logic [CfgAddrW-1:0] RegGainI      = 3'd2;
	localparam logic [CfgAddrW-1:0] RegGainD      = 3'd3;
	localparam logic [CfgAddrW-1:0] RegIntLimit   = 3'd4;
	localparam logic [CfgAddrW-1:0] RegBaseSpeed  = 3'd5;
	localparam logic [CfgAddrW-1:0] RegMotorOneLim = 3'd6;
	localparam logic [CfgAddrW-1:0] RegMotorTwoLim = 3'd7;

	// Register values after reset.
	localparam logic [PitchW-1:0]    RstSetpoint    = 16'd0;
	localparam logic [GainW-1:0]     RstGainP       = 20'd85197;
	localparam logic [GainW-1:0]     RstGainI       = 20'd151;
	localparam logic [GainW-1:0]     RstGainD       = 20'd131;
	localparam logic [LimitW-1:0]    RstIntLimit    = 23'd12800;
	localparam logic [SpeedW-1:0]    RstBaseSpeed   = 16'd110;
	localparam logic [MotorLimW-1:0] RstMotorOneLim = 32'd11141226;
	localparam logic [MotorLimW-1:0] RstMotorTwoLim = 32'd9830506;

endpackage

`default_nettype wire

// File: src/pdmm_if.sv
// Valid/ready channel interfaces for pitch samples, duty results and register writes.
// Depends on pdmm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pdmm_pitch_if;
	logic                                valid;
	logic                                ready;
	logic signed [pdmm_pkg::PitchW-1:0]  pitch;

	modport source (output valid, output pitch, input ready);
	modport sink   (input valid, input pitch, output ready);
endinterface

interface pdmm_duty_if;
	logic                          valid;
	logic                          ready;
	logic [pdmm_pkg::DutyW-1:0]    motor_one_duty;
	logic [pdmm_pkg::DutyW-1:0]    motor_two_duty;

	modport source (output valid, output motor_one_duty, output motor_two_duty, input ready);
	modport sink   (input valid, input motor_one_duty, input motor_two_duty, output ready);
endinterface

interface pdmm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pdmm_pkg::CfgAddrW-1:0]    addr;
	logic [pdmm_pkg::CfgDataW-1:0]    data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: src/pid_differential_motor_mixer.sv
// PID pitch controller with integral clamp and a clamped differential two-motor mixer.
// Pipeline: an accepted request passes stage registers one to five, then the output register.
// Throughput: one request per cycle unless stalled; the integral and last-error loop
// closes in stage two. Each stage moves on when the next is empty or moving, so bubbles fill.
// Reset: registers return to their defaults, integral and last error clear, pipeline empties.
// Depends on pdmm_pkg and the channel interfaces in pdmm_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module pid_differential_motor_mixer (
	input  wire            clk,
	input  wire            arst_n,
	pdmm_cfg_if.sink       cfg,
	pdmm_pitch_if.sink     sample,
	pdmm_duty_if.source    result
);

	// Configuration registers.
	logic signed [pdmm_pkg::PitchW-1:0]  setpoint_q;
	logic [pdmm_pkg::GainW-1:0]          gain_p_q;
	logic [pdmm_pkg::GainW-1:0]          gain_i_q;
	logic [pdmm_pkg::GainW-1:0]          gain_d_q;
	logic [pdmm_pkg::LimitW-1:0]         int_limit_q;
	logic [pdmm_pkg::SpeedW-1:0]         base_speed_q;
	logic [pdmm_pkg::MotorLimW-1:0]      motor_one_lim_q;
	logic [pdmm_pkg::MotorLimW-1:0]      motor_two_lim_q;

	// Controller state.
	logic signed [23:0] integral_q;
	logic signed [16:0] prev_err_q;

	// Pipeline valid bits and load enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, out_valid_q;
	logic load_s1, load_s2, load_s3, load_s4, load_s5, load_out;

	// Pipeline payload.
	logic signed [15:0] pitch_s1;
	logic signed [16:0] err_s2;
	logic signed [23:0] integ_s2;
	logic signed [17:0] deriv_s2;
	logic signed [37:0] prod_p_s3;
	logic signed [44:0] prod_i_s3;
	logic signed [38:0] prod_d_s3;
	logic signed [46:0] sum_s4;
	logic signed [22:0] drive_s5;
	logic [pdmm_pkg::DutyW-1:0] duty_one_q;
	logic [pdmm_pkg::DutyW-1:0] duty_two_q;

	// Combinational values.
	logic signed [16:0] err_c;
	logic signed [24:0] acc_c;
	logic signed [24:0] lim_pos_c;
	logic signed [24:0] lim_neg_c;
	logic signed [23:0] integ_c;
	logic signed [17:0] deriv_c;
	logic signed [46:0] sum_c;
	logic signed [22:0] drive_c;
	logic               round_up_c;
	logic signed [24:0] base_c;
	logic signed [24:0] drive_ext_c;
	logic signed [24:0] mix_one_c;
	logic signed [24:0] mix_two_c;

	// Clamp a mixer sum to max first, then raise it to min, so min wins.
	function automatic logic [15:0] clamp_duty(input logic signed [24:0] v,
			input logic [31:0] lim);
		logic signed [24:0] hi;
		logic signed [24:0] lo;
		logic signed [24:0] r;
		hi = signed'({9'b0, lim[31:16]});
		lo = signed'({9'b0, lim[15:0]});
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r[15:0];
	endfunction

	// Register writes are always taken; unknown bits above each width are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q      <= pdmm_pkg::RstSetpoint;
			gain_p_q        <= pdmm_pkg::RstGainP;
			gain_i_q        <= pdmm_pkg::RstGainI;
			gain_d_q        <= pdmm_pkg::RstGainD;
			int_limit_q     <= pdmm_pkg::RstIntLimit;
			base_speed_q    <= pdmm_pkg::RstBaseSpeed;
			motor_one_lim_q <= pdmm_pkg::RstMotorOneLim;
			motor_two_lim_q <= pdmm_pkg::RstMotorTwoLim;
		end else if (cfg.valid) begin
			case (cfg.addr)
				pdmm_pkg::RegSetpoint:    setpoint_q      <= cfg.data[15:0];
				pdmm_pkg::RegGainP:       gain_p_q        <= cfg.data[19:0];
				pdmm_pkg::RegGainI:       gain_i_q        <= cfg.data[19:0];
				pdmm_pkg::RegGainD:       gain_d_q        <= cfg.data[19:0];
				pdmm_pkg::RegIntLimit:    int_limit_q     <= cfg.data[22:0];
				pdmm_pkg::RegBaseSpeed:   base_speed_q    <= cfg.data[15:0];
				pdmm_pkg::RegMotorOneLim: motor_one_lim_q <= cfg.data;
				pdmm_pkg::RegMotorTwoLim: motor_two_lim_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Stall chain: a stage loads when it is empty or its content moves on.
	assign load_out = !out_valid_q || result.ready;
	assign load_s5  = !valid_s5 || load_out;
	assign load_s4  = !valid_s4 || load_s5;
	assign load_s3  = !valid_s3 || load_s4;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign sample.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1)  valid_s1    <= sample.valid;
			if (load_s2)  valid_s2    <= valid_s1;
			if (load_s3)  valid_s3    <= valid_s2;
			if (load_s4)  valid_s4    <= valid_s3;
			if (load_s5)  valid_s5    <= valid_s4;
			if (load_out) out_valid_q <= valid_s5;
		end
	end

	// Stage two: error, clamped integral and derivative.
	always_comb begin
		err_c     = 17'(setpoint_q) - 17'(pitch_s1);
		acc_c     = 25'(integral_q) + 25'(err_c);
		lim_pos_c = signed'({2'b0, int_limit_q});
		lim_neg_c = -lim_pos_c;
		if (acc_c > lim_pos_c) begin
			integ_c = lim_pos_c[23:0];
		end else if (acc_c < lim_neg_c) begin
			integ_c = lim_neg_c[23:0];
		end else begin
			integ_c = acc_c[23:0];
		end
		deriv_c = 18'(err_c) - 18'(prev_err_q);
	end

	// The integral and last error advance once per sample leaving stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
		end else if (valid_s1 && load_s2) begin
			integral_q <= integ_c;
			prev_err_q <= err_c;
		end
	end

	// Stage four: exact sum of the three products.
	assign sum_c = 47'(prod_p_s3) + 47'(prod_i_s3) + 47'(prod_d_s3);

	// Stage five: drop the 24 fraction bits, rounding toward zero.
	assign round_up_c = sum_s4[46] && (|sum_s4[23:0]);
	assign drive_c    = sum_s4[46:24] + 23'(round_up_c);

	// Output stage: differential mix in the signed domain, then per-motor clamp.
	always_comb begin
		base_c      = signed'({9'b0, base_speed_q});
		drive_ext_c = 25'(drive_s5);
		mix_one_c   = base_c + drive_ext_c;
		mix_two_c   = base_c - drive_ext_c;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			pitch_s1 <= sample.pitch;
		end
		if (load_s2) begin
			err_s2   <= err_c;
			integ_s2 <= integ_c;
			deriv_s2 <= deriv_c;
		end
		if (load_s3) begin
			prod_p_s3 <= err_s2 * signed'({1'b0, gain_p_q});
			prod_i_s3 <= integ_s2 * signed'({1'b0, gain_i_q});
			prod_d_s3 <= deriv_s2 * signed'({1'b0, gain_d_q});
		end
		if (load_s4) begin
			sum_s4 <= sum_c;
		end
		if (load_s5) begin
			drive_s5 <= drive_c;
		end
		if (load_out) begin
			duty_one_q <= clamp_duty(mix_one_c, motor_one_lim_q);
			duty_two_q <= clamp_duty(mix_two_c, motor_two_lim_q);
		end
	end

	assign result.valid          = out_valid_q;
	assign result.motor_one_duty = duty_one_q;
	assign result.motor_two_duty = duty_two_q;

	// The integral never leaves the limit right after an update.
	a_integral_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_s2) |=>
		(25'(integral_q) <= signed'({2'b0, int_limit_q}) &&
		 25'(integral_q) >= -signed'({2'b0, int_limit_q})))
		else $error("integral left its limit");

	// Controller state holds while no sample leaves stage one.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && load_s2) |=> ($stable(integral_q) && $stable(prev_err_q)))
		else $error("controller state changed without a sample");

	// With an ordered window, motor one stays inside it.
	a_duty_one_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && motor_one_lim_q[31:16] >= motor_one_lim_q[15:0]) |->
		(duty_one_q <= motor_one_lim_q[31:16] && duty_one_q >= motor_one_lim_q[15:0]))
		else $error("motor one duty outside its window");

	// With an ordered window, motor two stays inside it.
	a_duty_two_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && motor_two_lim_q[31:16] >= motor_two_lim_q[15:0]) |->
		(duty_two_q <= motor_two_lim_q[31:16] && duty_two_q >= motor_two_lim_q[15:0]))
		else $error("motor two duty outside its window");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the PID pitch controller with its differential motor mixer.
// Sends pitch requests and register writes, predicts both duties and checks every result.
// Depends on pdmm_pkg, the channel interfaces in pdmm_if.sv and pid_differential_motor_mixer.
`timescale 1ns / 1ps

module testbench;

	localparam int NumPhases       = 8;
	localparam int SamplesPerPhase = 240;
	localparam int IdleLimit       = 1000;
	localparam int DrainCycles     = 20;
	localparam int SettleCycles    = 8;

	typedef enum bit {RowSample, RowWrite} row_kind_t;
	typedef enum int {RxOpen, RxRandom, RxPeriodic, RxSparse} rx_mode_t;

	typedef struct {
		row_kind_t                     kind;
		logic [pdmm_pkg::CfgAddrW-1:0] addr;
		logic [pdmm_pkg::CfgDataW-1:0] data;
		logic [pdmm_pkg::PitchW-1:0]   pitch;
		bit                            typed;
		logic [pdmm_pkg::DutyW-1:0]    one;
		logic [pdmm_pkg::DutyW-1:0]    two;
	} stim_row_t;

	typedef struct {
		logic [pdmm_pkg::DutyW-1:0] one;
		logic [pdmm_pkg::DutyW-1:0] two;
	} duty_pair_t;

	logic clk;
	logic arst_n;

	pdmm_cfg_if   cfg_ch ();
	pdmm_pitch_if pitch_ch ();
	pdmm_duty_if  duty_ch ();

	pid_differential_motor_mixer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (pitch_ch),
		.result (duty_ch)
	);

	// Controller registers and loop state as the testbench tracks them.
	logic signed [pdmm_pkg::PitchW-1:0] sp_reg      = pdmm_pkg::RstSetpoint;
	logic [pdmm_pkg::GainW-1:0]         kp_reg      = pdmm_pkg::RstGainP;
	logic [pdmm_pkg::GainW-1:0]         ki_reg      = pdmm_pkg::RstGainI;
	logic [pdmm_pkg::GainW-1:0]         kd_reg      = pdmm_pkg::RstGainD;
	logic [pdmm_pkg::LimitW-1:0]        ilim_reg    = pdmm_pkg::RstIntLimit;
	logic [pdmm_pkg::SpeedW-1:0]        base_reg    = pdmm_pkg::RstBaseSpeed;
	logic [pdmm_pkg::MotorLimW-1:0]     one_lim_reg = pdmm_pkg::RstMotorOneLim;
	logic [pdmm_pkg::MotorLimW-1:0]     two_lim_reg = pdmm_pkg::RstMotorTwoLim;
	logic signed [23:0]                 integ_acc   = '0;
	logic signed [16:0]                 last_err    = '0;

	duty_pair_t duty_queue [$];
	duty_pair_t head;
	stim_row_t  dir_rows [$];
	int         n_fail      = 0;
	int         burst_left  = 1;
	int         idle_cycles = 0;
	rx_mode_t   rx_mode     = RxOpen;
	int         rx_left     = 0;
	int         rx_tick     = 0;

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Clamp a signed mixer sum into [min, max]; min is applied last, so it wins.
	function automatic logic [pdmm_pkg::DutyW-1:0] clamp_duty(input longint v,
			input logic [pdmm_pkg::MotorLimW-1:0] lims);
		longint hi;
		longint lo;
		longint r;
		hi = longint'(lims[31:16]);
		lo = longint'(lims[15:0]);
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r[pdmm_pkg::DutyW-1:0];
	endfunction

	// Advance the integral and last error by one sample and work out both duties.
	function automatic duty_pair_t predict_duties(
			input logic signed [pdmm_pkg::PitchW-1:0] p);
		longint e;
		longint lim;
		longint acc;
		longint dv;
		longint drive;
		duty_pair_t d;
		e = longint'(sp_reg) - longint'(p);
		lim = longint'(ilim_reg);
		acc = longint'(integ_acc) + e;
		if (acc > lim) acc = lim;
		if (acc < -lim) acc = -lim;
		integ_acc = acc[23:0];
		dv = e - longint'(last_err);
		last_err = e[16:0];
		// Exact Q.24 sum, truncated toward zero to whole counts.
		drive = (longint'(kp_reg) * e + longint'(ki_reg) * longint'(integ_acc)
			+ longint'(kd_reg) * dv) / 64'sd16777216;
		d.one = clamp_duty(longint'(base_reg) + drive, one_lim_reg);
		d.two = clamp_duty(longint'(base_reg) - drive, two_lim_reg);
		return d;
	endfunction

	// Track a register write; bits above each register's width are dropped.
	function automatic void apply_write(input logic [pdmm_pkg::CfgAddrW-1:0] a,
			input logic [pdmm_pkg::CfgDataW-1:0] d);
		case (a)
			pdmm_pkg::RegSetpoint:    sp_reg = d[pdmm_pkg::PitchW-1:0];
			pdmm_pkg::RegGainP:       kp_reg = d[pdmm_pkg::GainW-1:0];
			pdmm_pkg::RegGainI:       ki_reg = d[pdmm_pkg::GainW-1:0];
			pdmm_pkg::RegGainD:       kd_reg = d[pdmm_pkg::GainW-1:0];
			pdmm_pkg::RegIntLimit:    ilim_reg = d[pdmm_pkg::LimitW-1:0];
			pdmm_pkg::RegBaseSpeed:   base_reg = d[pdmm_pkg::SpeedW-1:0];
			pdmm_pkg::RegMotorOneLim: one_lim_reg = d;
			pdmm_pkg::RegMotorTwoLim: two_lim_reg = d;
			default: ;
		endcase
	endfunction

	// Fill the bits above a register's width with noise.
	function automatic logic [pdmm_pkg::CfgDataW-1:0] pad_word(
			input logic [pdmm_pkg::CfgDataW-1:0] v, input int w);
		logic [pdmm_pkg::CfgDataW-1:0] mask;
		mask = (w >= pdmm_pkg::CfgDataW) ? {pdmm_pkg::CfgDataW{1'b1}}
			: ((32'd1 << w) - 32'd1);
		return (v & mask) | ($urandom & ~mask);
	endfunction

	function automatic logic [pdmm_pkg::GainW-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return 20'($urandom);
			default: return 20'($urandom_range(0, 131072));
		endcase
	endfunction

	// Motor limits: full window in phase five, mostly min below max, sometimes anything at all.
	function automatic logic [pdmm_pkg::MotorLimW-1:0] pick_limits(input int ph);
		logic [15:0] lo;
		logic [15:0] hi;
		if (ph == 5) return {16'hFFFF, 16'h0000};
		if ($urandom_range(0, 3) == 0) return $urandom;
		lo = 16'($urandom_range(0, 40000));
		hi = 16'(lo + $urandom_range(0, 65535 - lo));
		return {hi, lo};
	endfunction

	function automatic stim_row_t write_row(input logic [pdmm_pkg::CfgAddrW-1:0] a,
			input logic [pdmm_pkg::CfgDataW-1:0] d);
		stim_row_t r;
		r.kind = RowWrite;
		r.addr = a;
		r.data = d;
		r.pitch = '0;
		r.typed = 1'b0;
		r.one = '0;
		r.two = '0;
		return r;
	endfunction

	function automatic stim_row_t sample_row(input logic [pdmm_pkg::PitchW-1:0] p,
			input bit typed, input logic [pdmm_pkg::DutyW-1:0] one,
			input logic [pdmm_pkg::DutyW-1:0] two);
		stim_row_t r;
		r.kind = RowSample;
		r.addr = '0;
		r.data = '0;
		r.pitch = p;
		r.typed = typed;
		r.one = one;
		r.two = two;
		return r;
	endfunction

	// Write one register once the pipeline has drained.
	task automatic write_reg(input logic [pdmm_pkg::CfgAddrW-1:0] a,
			input logic [pdmm_pkg::CfgDataW-1:0] d);
		pitch_ch.valid <= 1'b0;
		while (duty_queue.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= a;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		apply_write(a, d);
	endtask

	// Send one pitch request and queue its duties; the sender pauses between bursts.
	task automatic send_pitch(input logic [pdmm_pkg::PitchW-1:0] p, input bit typed,
			input duty_pair_t typed_duty);
		duty_pair_t pred;
		pitch_ch.valid <= 1'b1;
		pitch_ch.pitch <= p;
		@(posedge clk);
		while (!pitch_ch.ready) @(posedge clk);
		pred = predict_duties(p);
		if (typed)
			duty_queue.push_back(typed_duty);
		else
			duty_queue.push_back(pred);
		burst_left--;
		if (burst_left <= 0) begin
			pitch_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(1, 12);
		end
	endtask

	// Result ready follows a stall pattern of its own, switched every so often.
	always @(posedge clk) begin
		if (rx_left <= 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RxOpen:     duty_ch.ready <= 1'b1;
			RxRandom:   duty_ch.ready <= ($urandom_range(0, 2) != 0);
			RxPeriodic: duty_ch.ready <= (rx_tick % 16 == 0);
			default:    duty_ch.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (duty_ch.valid === 1'b1 && duty_ch.ready === 1'b1) begin
			if (duty_queue.size() == 0) begin
				$error("result with no request pending: motor_one_duty %0d motor_two_duty %0d",
					duty_ch.motor_one_duty, duty_ch.motor_two_duty);
				n_fail++;
			end else begin
				head = duty_queue.pop_front();
				if (duty_ch.motor_one_duty !== head.one) begin
					$error("motor_one_duty: expected %0d, actual %0d",
						head.one, duty_ch.motor_one_duty);
					n_fail++;
				end
				if (duty_ch.motor_two_duty !== head.two) begin
					$error("motor_two_duty: expected %0d, actual %0d",
						head.two, duty_ch.motor_two_duty);
					n_fail++;
				end
			end
		end
	end

	// Watchdog: too long without any request moving on any channel.
	always @(posedge clk) begin
		if ((pitch_ch.valid === 1'b1 && pitch_ch.ready === 1'b1)
				|| (duty_ch.valid === 1'b1 && duty_ch.ready === 1'b1)
				|| (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("pid_differential_motor_mixer regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		logic [pdmm_pkg::CfgDataW-1:0] d;
		logic [pdmm_pkg::PitchW-1:0]   p;
		duty_pair_t                    want;

		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
		pitch_ch.valid = 1'b0;
		pitch_ch.pitch = '0;
		want.one = '0;
		want.two = '0;

		// Directed rows: reset values, field extremes, zero integral limit,
		// min above max, a zero-width limit window and both base extremes.
		dir_rows.push_back(sample_row(16'h0000, 1'b1, 16'd110, 16'd110));
		dir_rows.push_back(sample_row(16'h8000, 1'b1, 16'd170, 16'd106));
		dir_rows.push_back(sample_row(16'h7FFF, 1'b0, '0, '0));
		dir_rows.push_back(sample_row(16'h0000, 1'b0, '0, '0));
		dir_rows.push_back(write_row(pdmm_pkg::RegIntLimit, 32'hFF80_0000));
		dir_rows.push_back(sample_row(16'h1234, 1'b0, '0, '0));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainP, 32'hFFFF_FFFF));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainI, 32'hFFFF_FFFF));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainD, 32'hFFFF_FFFF));
		dir_rows.push_back(sample_row(16'h8000, 1'b0, '0, '0));
		dir_rows.push_back(sample_row(16'h7FFF, 1'b0, '0, '0));
		dir_rows.push_back(write_row(pdmm_pkg::RegSetpoint, 32'h1234_8000));
		dir_rows.push_back(sample_row(16'h7FFF, 1'b0, '0, '0));
		dir_rows.push_back(write_row(pdmm_pkg::RegSetpoint, 32'hABCD_7FFF));
		dir_rows.push_back(sample_row(16'h8000, 1'b0, '0, '0));
		dir_rows.push_back(write_row(pdmm_pkg::RegBaseSpeed, 32'h5A5A_FFFF));
		dir_rows.push_back(write_row(pdmm_pkg::RegMotorOneLim, {16'd100, 16'd200}));
		dir_rows.push_back(write_row(pdmm_pkg::RegMotorTwoLim, 32'h0000_0000));
		dir_rows.push_back(sample_row(16'h0000, 1'b1, 16'd200, 16'd0));
		dir_rows.push_back(write_row(pdmm_pkg::RegMotorOneLim, {16'hFFFF, 16'h0000}));
		dir_rows.push_back(write_row(pdmm_pkg::RegMotorTwoLim, {16'hFFFF, 16'h0000}));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainP, 32'hFFF0_0000));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainI, 32'hFFF0_0000));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainD, 32'hFFF0_0000));
		dir_rows.push_back(sample_row(16'h5A5A, 1'b1, 16'hFFFF, 16'hFFFF));
		dir_rows.push_back(write_row(pdmm_pkg::RegBaseSpeed, 32'hFFFF_0000));
		dir_rows.push_back(sample_row(16'hA5A5, 1'b1, 16'h0000, 16'h0000));
		dir_rows.push_back(write_row(pdmm_pkg::RegIntLimit, 32'h007F_FFFF));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainP, {12'd0, pdmm_pkg::RstGainP}));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainI, {12'd0, pdmm_pkg::RstGainI}));
		dir_rows.push_back(write_row(pdmm_pkg::RegGainD, {12'd0, pdmm_pkg::RstGainD}));
		dir_rows.push_back(write_row(pdmm_pkg::RegBaseSpeed,
			{16'd0, pdmm_pkg::RstBaseSpeed}));
		dir_rows.push_back(write_row(pdmm_pkg::RegMotorOneLim, pdmm_pkg::RstMotorOneLim));
		dir_rows.push_back(write_row(pdmm_pkg::RegMotorTwoLim, pdmm_pkg::RstMotorTwoLim));
		dir_rows.push_back(sample_row(16'hFFFF, 1'b0, '0, '0));
		dir_rows.push_back(sample_row(16'h0001, 1'b0, '0, '0));
		dir_rows.push_back(sample_row(16'h8000, 1'b0, '0, '0));
		dir_rows.push_back(sample_row(16'h7FFF, 1'b0, '0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == RowWrite) begin
				write_reg(dir_rows[i].addr, dir_rows[i].data);
			end else begin
				want.one = dir_rows[i].one;
				want.two = dir_rows[i].two;
				send_pitch(dir_rows[i].pitch, dir_rows[i].typed, want);
			end
		end

		// Random phases, each with a fresh setting of every register.
		for (int ph = 0; ph < NumPhases; ph++) begin
			d = $urandom;
			if (ph == 1)
				d[15:0] = 16'h8000;
			else if (ph == 2)
				d[15:0] = 16'h7FFF;
			else if (ph % 2 == 1)
				d[15:0] = 16'($urandom_range(0, 2048) - 1024);
			write_reg(pdmm_pkg::RegSetpoint, d);

			write_reg(pdmm_pkg::RegGainP,
				pad_word((ph == 3) ? '1 : pick_gain(), pdmm_pkg::GainW));
			write_reg(pdmm_pkg::RegGainI,
				pad_word((ph == 3) ? '1 : pick_gain(), pdmm_pkg::GainW));
			write_reg(pdmm_pkg::RegGainD,
				pad_word((ph == 3) ? '1 : pick_gain(), pdmm_pkg::GainW));

			if (ph == 4)
				d = pad_word('0, pdmm_pkg::LimitW);
			else if (ph == 5)
				d = pad_word('1, pdmm_pkg::LimitW);
			else if ($urandom_range(0, 1) == 0)
				d = pad_word($urandom_range(0, 65536), pdmm_pkg::LimitW);
			else
				d = pad_word($urandom, pdmm_pkg::LimitW);
			write_reg(pdmm_pkg::RegIntLimit, d);

			if (ph == 6)
				d = pad_word('0, pdmm_pkg::SpeedW);
			else if (ph == 7)
				d = pad_word('1, pdmm_pkg::SpeedW);
			else
				d = pad_word($urandom, pdmm_pkg::SpeedW);
			write_reg(pdmm_pkg::RegBaseSpeed, d);

			write_reg(pdmm_pkg::RegMotorOneLim, pick_limits(ph));
			write_reg(pdmm_pkg::RegMotorTwoLim, pick_limits(ph));

			// Mostly pitch near the setpoint, some noise and extremes.
			for (int n = 0; n < SamplesPerPhase; n++) begin
				case ($urandom_range(0, 9))
					0: p = 16'($urandom);
					1: begin
						case ($urandom_range(0, 3))
							0: p = 16'h8000;
							1: p = 16'h7FFF;
							2: p = 16'h0000;
							default: p = 16'hFFFF;
						endcase
					end
					default: p = 16'(sp_reg + ($urandom_range(0, 4096) - 2048));
				endcase
				send_pitch(p, 1'b0, want);
			end
		end

		// Drain and report.
		pitch_ch.valid <= 1'b0;
		while (duty_queue.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (n_fail == 0)
			$display("pid_differential_motor_mixer regression: pass");
		else
			$display("pid_differential_motor_mixer regression: fail");
		$finish;
	end

endmodule

// File: files.f
src/pdmm_pkg.sv
src/pdmm_if.sv
src/pid_differential_motor_mixer.sv
tb/sv/testbench.sv
